// ===== design/bts_pkg.sv =====
// Shared types, constants and the heap-order compare for the balanced top-K selector.
package bts_pkg;

    // Heap geometry
    localparam int HEAP_SLOTS = 10;
    localparam int ADDR_W     = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
    localparam int CNT_W      = $clog2(HEAP_SLOTS + 1);

    // Field widths
    localparam int SCORE_W   = 16;
    localparam int INDEX_W   = 16;
    localparam int BAND_W    = 15;
    localparam int CFG_IDX_W = 1;
    localparam int ENTRY_W   = SCORE_W + INDEX_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 1'b1;

    // Band limits after reset (Q1.14: 0.5 and 1.0)
    localparam logic [BAND_W-1:0] BAND_LOW_RST  = 15'd8192;
    localparam logic [BAND_W-1:0] BAND_HIGH_RST = 15'd16384;

    // Transaction kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    // Compare unit selection codes
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_CUR = 2'd0;
    localparam t_sel SEL_L   = 2'd1;
    localparam t_sel SEL_R   = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        item_index;
    } t_in;

    typedef struct packed {
        logic [INDEX_W-1:0] sel_index;
        logic               sel_label;
        logic               sel_valid;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
    } t_entry;

    // True when a should leave the heap before b (min-heap for positive,
    // max-heap for negative)
    function automatic logic worse(input logic neg,
                                   input logic signed [SCORE_W-1:0] a,
                                   input logic signed [SCORE_W-1:0] b);
        return neg ? (a > b) : (a < b);
    endfunction

endpackage

// ===== design/bts_ram.sv =====
// Generic one-write, two-read RAM with registered read data.
module bts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== design/bts_cmp.sv =====
// Shared compare unit: picks the entry to sit highest among a slot and its two children.
module bts_cmp import bts_pkg::*; (
    input  logic                      i_neg,
    input  logic signed [SCORE_W-1:0] i_cur,
    input  logic signed [SCORE_W-1:0] i_l,
    input  logic                      i_l_ok,
    input  logic signed [SCORE_W-1:0] i_r,
    input  logic                      i_r_ok,
    output t_sel                      o_sel
);

    logic signed [SCORE_W-1:0] w_best;

    // Left child beats the slot first, then right child beats that winner
    always_comb begin
        w_best = i_cur;
        o_sel  = SEL_CUR;
        if (i_l_ok && worse(i_neg, i_l, w_best)) begin
            o_sel  = SEL_L;
            w_best = i_l;
        end
        if (i_r_ok && worse(i_neg, i_r, w_best)) begin
            o_sel = SEL_R;
        end
    end

endmodule

// ===== design/band_topk_balanced_selector.sv =====
// Balanced top-K selector: two score heaps, shared sift-down compare, drain walker.
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction of
//   kind clear, offer or drain. The block works on one transaction at a time and
//   holds o_in_ready low until it is done.
//   A clear completes without leaving idle. An offer whose magnitude lies strictly
//   inside the band passes a root check and then one sift-down step per heap level
//   visited; an offer outside the band is dropped without leaving idle.
//   The sift-down does one compare-and-move per cycle in the shared compare unit,
//   fed by the heap RAM's two registered read ports.
//   A drain walks the slots from the last one up to the root, one slot at a time, and
//   emits up to 2*HEAP_SLOTS result transactions on o_out_valid / i_out_ready;
//   the final one carries last. An empty drain gives one record with
//   sel_valid low and last high.
//   The output register stalls the drain walk while the receiver holds
//   i_out_ready low; no result is dropped.
//   Configuration (i_cfg_valid / o_cfg_ready) writes band_low (index 0) or
//   band_high (index 1), is always ready, and should be used while idle.
//   Reset (i_rst_n low, synchronous) empties both heaps and restores the band
//   limits to 0.5 and 1.0.
module band_topk_balanced_selector import bts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BAND_W-1:0]    i_cfg_data
);

    localparam int PTR_W = ADDR_W + 2;
    localparam logic [PTR_W-1:0] HEAP_N = PTR_W'(HEAP_SLOTS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ROOT     = 3'd1;
    localparam logic [2:0] S_STEP     = 3'd2;
    localparam logic [2:0] S_DR_RD    = 3'd3;
    localparam logic [2:0] S_DR_POS   = 3'd4;
    localparam logic [2:0] S_DR_NEG   = 3'd5;
    localparam logic [2:0] S_DR_EMPTY = 3'd6;

    logic [2:0]          r_state, n_state;
    logic                r_neg, n_neg;
    t_entry              r_hold, n_hold;
    logic                r_hold_used, n_hold_used;
    logic [ADDR_W-1:0]   r_cur, n_cur;
    logic                r_l_ok, n_l_ok;
    logic                r_r_ok, n_r_ok;
    logic [HEAP_SLOTS-1:0] r_used_pos, n_used_pos;
    logic [HEAP_SLOTS-1:0] r_used_neg, n_used_neg;
    logic [CNT_W-1:0]    r_cnt_pos, n_cnt_pos;
    logic [CNT_W-1:0]    r_cnt_neg, n_cnt_neg;
    logic [CNT_W-1:0]    r_rem_pos, n_rem_pos;
    logic [CNT_W-1:0]    r_rem_neg, n_rem_neg;
    logic [ADDR_W-1:0]   r_slot, n_slot;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;
    logic [BAND_W-1:0]   r_band_low;
    logic [BAND_W-1:0]   r_band_high;
    logic                r_ua_pos, r_ub_pos, r_ua_neg, r_ub_neg;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_emit;
    logic [SCORE_W:0]    w_mag;
    logic                w_in_band;
    logic [CNT_W-1:0]    w_min;
    logic [ENTRY_W-1:0]  w_ram_a_pos, w_ram_b_pos, w_ram_a_neg, w_ram_b_neg;
    t_entry              w_a_pos, w_b_pos, w_a_neg, w_b_neg;
    t_entry              w_ea, w_eb;
    logic                w_ua, w_ub;
    logic                w_cmp_l_ok, w_cmp_r_ok;
    t_sel                w_sel;
    logic [PTR_W-1:0]    w_cl_full, w_cr_full, w_nl_full, w_nr_full;
    logic [ADDR_W-1:0]   w_next_cur, w_addr_a, w_addr_b;
    logic                w_we;
    t_entry              w_wdata;
    logic                w_wused;
    logic                w_neg_want;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Magnitude in one extra bit so the most negative score keeps its size
    assign w_mag = i_in_data.score[SCORE_W-1]
                 ? ((SCORE_W+1)'(0) - {i_in_data.score[SCORE_W-1], i_in_data.score})
                 : {1'b0, i_in_data.score};
    assign w_in_band = (w_mag > {2'b00, r_band_low}) && (w_mag < {2'b00, r_band_high});
    assign w_min     = (r_cnt_pos < r_cnt_neg) ? r_cnt_pos : r_cnt_neg;

    // Empty slots read as score 0, index 0
    assign w_a_pos = r_ua_pos ? t_entry'(w_ram_a_pos) : '0;
    assign w_b_pos = r_ub_pos ? t_entry'(w_ram_b_pos) : '0;
    assign w_a_neg = r_ua_neg ? t_entry'(w_ram_a_neg) : '0;
    assign w_b_neg = r_ub_neg ? t_entry'(w_ram_b_neg) : '0;
    assign w_ea    = r_neg ? w_a_neg : w_a_pos;
    assign w_eb    = r_neg ? w_b_neg : w_b_pos;
    assign w_ua    = r_neg ? r_ua_neg : r_ua_pos;
    assign w_ub    = r_neg ? r_ub_neg : r_ub_pos;

    // Compare operands: root check against the new score, or a sift step
    always_comb begin
        w_cmp_l_ok = 1'b0;
        w_cmp_r_ok = 1'b0;
        if (r_state == S_ROOT) begin
            w_cmp_l_ok = 1'b1;
        end else if (r_state == S_STEP) begin
            w_cmp_l_ok = r_l_ok;
            w_cmp_r_ok = r_r_ok;
        end
    end

    bts_cmp u_cmp (
        .i_neg  (r_neg),
        .i_cur  (r_hold.score),
        .i_l    (w_ea.score),
        .i_l_ok (w_cmp_l_ok),
        .i_r    (w_eb.score),
        .i_r_ok (w_cmp_r_ok),
        .o_sel  (w_sel)
    );

    // Child addresses of the current slot and of the slot visited next
    assign w_cl_full = {1'b0, r_cur, 1'b1};
    assign w_cr_full = w_cl_full + PTR_W'(1);

    always_comb begin
        w_next_cur = '0;
        if (r_state == S_STEP) begin
            w_next_cur = (w_sel == SEL_R) ? w_cr_full[ADDR_W-1:0] : w_cl_full[ADDR_W-1:0];
        end
    end

    assign w_nl_full = {1'b0, w_next_cur, 1'b1};
    assign w_nr_full = w_nl_full + PTR_W'(1);

    // Read addresses: root while idle, slot walker in a drain, children otherwise
    always_comb begin
        w_addr_a = w_nl_full[ADDR_W-1:0];
        w_addr_b = w_nr_full[ADDR_W-1:0];
        if (r_state == S_IDLE) begin
            w_addr_a = '0;
            w_addr_b = '0;
        end else if (r_state == S_DR_RD || r_state == S_DR_POS || r_state == S_DR_NEG ||
                     r_state == S_DR_EMPTY) begin
            w_addr_a = r_slot;
            w_addr_b = r_slot;
        end
    end

    bts_ram #(.DEPTH(HEAP_SLOTS), .WIDTH(ENTRY_W)) u_ram_pos (
        .i_clk     (i_clk),
        .i_we      (w_we && !r_neg),
        .i_waddr   (r_cur),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_addr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_ram_a_pos),
        .o_rdata_b (w_ram_b_pos)
    );

    bts_ram #(.DEPTH(HEAP_SLOTS), .WIDTH(ENTRY_W)) u_ram_neg (
        .i_clk     (i_clk),
        .i_we      (w_we && r_neg),
        .i_waddr   (r_cur),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_addr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_ram_a_neg),
        .o_rdata_b (w_ram_b_neg)
    );

    // Used flags follow the read data so they line up with the RAM output
    always_ff @(posedge i_clk) begin
        r_ua_pos <= (PTR_W'(w_addr_a) < HEAP_N) ? r_used_pos[w_addr_a] : 1'b0;
        r_ub_pos <= (PTR_W'(w_addr_b) < HEAP_N) ? r_used_pos[w_addr_b] : 1'b0;
        r_ua_neg <= (PTR_W'(w_addr_a) < HEAP_N) ? r_used_neg[w_addr_a] : 1'b0;
        r_ub_neg <= (PTR_W'(w_addr_b) < HEAP_N) ? r_used_neg[w_addr_b] : 1'b0;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_hold      = r_hold;
        n_hold_used = r_hold_used;
        n_cur       = r_cur;
        n_l_ok      = r_l_ok;
        n_r_ok      = r_r_ok;
        n_used_pos  = r_used_pos;
        n_used_neg  = r_used_neg;
        n_cnt_pos   = r_cnt_pos;
        n_cnt_neg   = r_cnt_neg;
        n_rem_pos   = r_rem_pos;
        n_rem_neg   = r_rem_neg;
        n_slot      = r_slot;
        n_out       = r_out;
        w_emit      = 1'b0;
        w_we        = 1'b0;
        w_wdata     = r_hold;
        w_wused     = r_hold_used;
        w_neg_want  = r_ua_neg && (r_rem_neg != '0);

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_data.kind)
                        KIND_CLEAR: begin
                            n_used_pos = '0;
                            n_used_neg = '0;
                            n_cnt_pos  = '0;
                            n_cnt_neg  = '0;
                        end
                        KIND_OFFER: begin
                            if (w_in_band) begin
                                n_neg       = i_in_data.score[SCORE_W-1];
                                n_hold      = '{score: i_in_data.score,
                                                index: i_in_data.item_index};
                                n_hold_used = 1'b1;
                                n_state     = S_ROOT;
                            end
                        end
                        KIND_DRAIN: begin
                            n_rem_pos = w_min;
                            n_rem_neg = w_min;
                            n_slot    = ADDR_W'(HEAP_SLOTS - 1);
                            n_state   = (w_min == '0) ? S_DR_EMPTY : S_DR_RD;
                        end
                        default: ;
                    endcase
                end
            end

            // Root keeps its place unless strictly worse than the new entry
            S_ROOT: begin
                if (w_sel != SEL_L) begin
                    n_hold      = w_ea;
                    n_hold_used = w_ua;
                end else if (!w_ua) begin
                    if (r_neg) begin
                        n_cnt_neg = r_cnt_neg + CNT_W'(1);
                    end else begin
                        n_cnt_pos = r_cnt_pos + CNT_W'(1);
                    end
                end
                n_cur   = '0;
                n_l_ok  = (w_nl_full < HEAP_N);
                n_r_ok  = (w_nr_full < HEAP_N);
                n_state = S_STEP;
            end

            // One sift level: move the winning child up, or park the held entry
            S_STEP: begin
                w_we = 1'b1;
                unique case (w_sel)
                    SEL_L: begin
                        w_wdata = w_ea;
                        w_wused = w_ua;
                        n_cur   = w_next_cur;
                        n_l_ok  = (w_nl_full < HEAP_N);
                        n_r_ok  = (w_nr_full < HEAP_N);
                    end
                    SEL_R: begin
                        w_wdata = w_eb;
                        w_wused = w_ub;
                        n_cur   = w_next_cur;
                        n_l_ok  = (w_nl_full < HEAP_N);
                        n_r_ok  = (w_nr_full < HEAP_N);
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                if (r_neg) begin
                    n_used_neg[r_cur] = w_wused;
                end else begin
                    n_used_pos[r_cur] = w_wused;
                end
            end

            S_DR_RD: begin
                n_state = S_DR_POS;
            end

            S_DR_POS: begin
                if (r_ua_pos && (r_rem_pos != '0)) begin
                    if (w_out_free) begin
                        w_emit    = 1'b1;
                        n_out     = '{sel_index: w_a_pos.index, sel_label: 1'b0,
                                      sel_valid: 1'b1,
                                      last: (r_rem_pos == CNT_W'(1)) && (r_rem_neg == '0)};
                        n_rem_pos = r_rem_pos - CNT_W'(1);
                        n_state   = S_DR_NEG;
                    end
                end else begin
                    n_state = S_DR_NEG;
                end
            end

            S_DR_NEG: begin
                if (!w_neg_want || w_out_free) begin
                    if (w_neg_want) begin
                        w_emit    = 1'b1;
                        n_out     = '{sel_index: w_a_neg.index, sel_label: 1'b1,
                                      sel_valid: 1'b1,
                                      last: (r_rem_neg == CNT_W'(1)) && (r_rem_pos == '0)};
                        n_rem_neg = r_rem_neg - CNT_W'(1);
                    end
                    if (((r_rem_pos == '0) && (n_rem_neg == '0)) || (r_slot == '0)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot  = r_slot - ADDR_W'(1);
                        n_state = S_DR_RD;
                    end
                end
            end

            S_DR_EMPTY: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_out   = '{sel_index: '0, sel_label: 1'b0, sel_valid: 1'b0,
                                last: 1'b1};
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = w_emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used_pos  <= '0;
            r_used_neg  <= '0;
            r_cnt_pos   <= '0;
            r_cnt_neg   <= '0;
            r_out_valid <= 1'b0;
            r_band_low  <= BAND_LOW_RST;
            r_band_high <= BAND_HIGH_RST;
        end else begin
            r_state     <= n_state;
            r_used_pos  <= n_used_pos;
            r_used_neg  <= n_used_neg;
            r_cnt_pos   <= n_cnt_pos;
            r_cnt_neg   <= n_cnt_neg;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BAND_LOW) begin
                    r_band_low <= i_cfg_data;
                end
                if (i_cfg_index == CFG_BAND_HIGH) begin
                    r_band_high <= i_cfg_data;
                end
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        r_neg       <= n_neg;
        r_hold      <= n_hold;
        r_hold_used <= n_hold_used;
        r_cur       <= n_cur;
        r_l_ok      <= n_l_ok;
        r_r_ok      <= n_r_ok;
        r_rem_pos   <= n_rem_pos;
        r_rem_neg   <= n_rem_neg;
        r_slot      <= n_slot;
        r_out       <= n_out;
    end

    // Fill counts track the used flags once a sift-down has finished
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
        ((r_cnt_pos == CNT_W'($countones(r_used_pos))) &&
         (r_cnt_neg == CNT_W'($countones(r_used_neg)))))
        else $error("heap fill count out of step with used flags");

    // A clear empties both heaps
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.kind == KIND_CLEAR)) |=>
        ((r_used_pos == '0) && (r_used_neg == '0)))
        else $error("clear left used entries");

    // The drain walk never modifies a heap
    a_drain_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DR_RD || r_state == S_DR_POS || r_state == S_DR_NEG ||
         r_state == S_DR_EMPTY) |-> !w_we)
        else $error("heap write during drain");

endmodule

// ===== tb/testbench.sv =====
// Testbench for the balanced top-K selector: directed table, then random band phases.
`timescale 1ns / 100ps

module testbench;
    import bts_pkg::*;

    // Run shape
    localparam int SETTLE_CYCLES = 20;    // longest offer sift-down, with margin
    localparam int TAIL_CYCLES   = 60;
    localparam int STALL_LIMIT   = 4000;  // cycles with no transaction at all
    localparam int HOLD_CYCLES   = 300;   // one long receiver hold-off
    localparam int HOLD_AFTER    = 40;    // results seen before the hold-off starts
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 55;

    // Kind code the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_dir_row;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BAND_LOW;
    logic [BAND_W-1:0]    cfg_data  = '0;

    // Predicted heaps: side 0 positive, side 1 negative
    logic signed [SCORE_W-1:0] hp_score [2][HEAP_SLOTS];
    logic [INDEX_W-1:0]        hp_index [2][HEAP_SLOTS];
    bit                        hp_used  [2][HEAP_SLOTS];
    logic [BAND_W-1:0]         band_lo;
    logic [BAND_W-1:0]         band_hi;

    t_out     sel_queue[$];
    t_dir_row dir_table[$];
    int       errors       = 0;
    int       results_seen = 0;
    int       idle_cycles  = 0;
    bit       calm         = 1'b0;

    // Clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    band_topk_balanced_selector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic t_in mk_in(logic [1:0] kind, int score, int idx);
        t_in it;
        it.kind       = kind;
        it.score      = score[SCORE_W-1:0];
        it.item_index = idx[INDEX_W-1:0];
        return it;
    endfunction

    function automatic t_out mk_sel(logic [INDEX_W-1:0] idx, bit label, bit valid, bit last);
        t_out r;
        r.sel_index = idx;
        r.sel_label = label;
        r.sel_valid = valid;
        r.last      = last;
        return r;
    endfunction

    // Append one row to the directed table
    task automatic add_row(t_in item, bit typed, t_out want);
        t_dir_row row;
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        dir_table = {dir_table, row};
    endtask

    // True when a leaves the heap before b
    function automatic bit evicts_first(bit neg, logic signed [SCORE_W-1:0] a,
                                        logic signed [SCORE_W-1:0] b);
        return neg ? (a > b) : (a < b);
    endfunction

    task automatic heap_clear();
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < HEAP_SLOTS; i++) begin
                hp_score[s][i] = '0;
                hp_index[s][i] = '0;
                hp_used[s][i]  = 1'b0;
            end
        end
    endtask

    // Root replace, then sift-down with strict compares, left child first
    task automatic heap_offer(bit side, logic signed [SCORE_W-1:0] s, logic [INDEX_W-1:0] ix);
        int                        cur;
        int                        m;
        bit                        done;
        logic signed [SCORE_W-1:0] ts;
        logic [INDEX_W-1:0]        ti;
        bit                        tu;
        if (evicts_first(side, hp_score[side][0], s)) begin
            hp_score[side][0] = s;
            hp_index[side][0] = ix;
            hp_used[side][0]  = 1'b1;
        end
        cur  = 0;
        done = 1'b0;
        while (!done) begin
            m = cur;
            if (2 * cur + 1 < HEAP_SLOTS) begin
                if (evicts_first(side, hp_score[side][2*cur+1], hp_score[side][m])) m = 2 * cur + 1;
            end
            if (2 * cur + 2 < HEAP_SLOTS) begin
                if (evicts_first(side, hp_score[side][2*cur+2], hp_score[side][m])) m = 2 * cur + 2;
            end
            if (m == cur) begin
                done = 1'b1;
            end else begin
                ts = hp_score[side][cur];
                ti = hp_index[side][cur];
                tu = hp_used[side][cur];
                hp_score[side][cur] = hp_score[side][m];
                hp_index[side][cur] = hp_index[side][m];
                hp_used[side][cur]  = hp_used[side][m];
                hp_score[side][m] = ts;
                hp_index[side][m] = ti;
                hp_used[side][m]  = tu;
                cur = m;
            end
        end
    endtask

    // Update predicted heaps for one accepted transaction, queue any drain results
    task automatic heap_apply(t_in it);
        logic [16:0] mag;
        int          pn;
        int          nn;
        t_out        drained[$];
        t_out        rec;
        case (it.kind)
            KIND_CLEAR: heap_clear();
            KIND_OFFER: begin
                mag = it.score[SCORE_W-1] ? 17'd0 - {1'b1, it.score} : {1'b0, it.score};
                if (mag > {2'b00, band_lo} && mag < {2'b00, band_hi})
                    heap_offer(it.score[SCORE_W-1], it.score, it.item_index);
            end
            KIND_DRAIN: begin
                pn = 0;
                nn = 0;
                for (int i = 0; i < HEAP_SLOTS; i++) begin
                    if (hp_used[0][i]) pn++;
                    if (hp_used[1][i]) nn++;
                end
                if (nn > pn) nn = pn;
                if (pn > nn) pn = nn;
                for (int i = HEAP_SLOTS - 1; i >= 0; i--) begin
                    if (pn > 0 && hp_used[0][i]) begin
                        pn--;
                        drained = {drained, mk_sel(hp_index[0][i], 1'b0, 1'b1, 1'b0)};
                    end
                    if (nn > 0 && hp_used[1][i]) begin
                        nn--;
                        drained = {drained, mk_sel(hp_index[1][i], 1'b1, 1'b1, 1'b0)};
                    end
                end
                if (drained.size() == 0) begin
                    drained = {drained, mk_sel('0, 1'b0, 1'b0, 1'b1)};
                end else begin
                    rec      = drained.pop_back();
                    rec.last = 1'b1;
                    drained  = {drained, rec};
                end
                sel_queue = {sel_queue, drained};
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
    endtask

    // Input transaction: optional idle burst, then hold valid until accepted
    task automatic send_item(t_in it, bit typed, t_out want);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        if (typed) sel_queue = {sel_queue, want};
        else heap_apply(it);
        @(negedge i_clk);
    endtask

    // Both band registers, back to back
    task automatic write_bands(logic [BAND_W-1:0] lo, logic [BAND_W-1:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BAND_LOW;
        cfg_data  <= lo;
        do @(posedge i_clk); while (!cfg_ready);
        band_lo = lo;
        @(negedge i_clk);
        cfg_index <= CFG_BAND_HIGH;
        cfg_data  <= hi;
        do @(posedge i_clk); while (!cfg_ready);
        band_hi = hi;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Block idle: nothing pending, last offer given time to finish its sift-down
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sel_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly in-band offers, with noise, boundaries, drains, clears and unused kinds
    function automatic t_in rand_item(logic [BAND_W-1:0] lo, logic [BAND_W-1:0] hi);
        int  r;
        int  mag;
        int  lo_i;
        int  hi_i;
        t_in it;
        lo_i          = int'(lo);
        hi_i          = int'(hi);
        r             = $urandom_range(0, 99);
        it.kind       = KIND_OFFER;
        it.score      = SCORE_W'($urandom_range(0, 65535));
        it.item_index = INDEX_W'($urandom_range(0, 65535));
        if (r < 68) begin
            if (hi_i > lo_i + 1) begin
                if ($urandom_range(0, 3) == 0) begin
                    // narrow spread near the lower bound gives ties
                    mag = lo_i + 1 + $urandom_range(0, 3);
                    if (mag > hi_i - 1) mag = hi_i - 1;
                end else begin
                    mag = $urandom_range(lo_i + 1, hi_i - 1);
                end
                it.score = SCORE_W'($urandom_range(0, 1) ? -mag : mag);
            end
        end else if (r < 78) begin
            // full-range noise score
        end else if (r < 81) begin
            mag      = $urandom_range(0, 1) ? lo_i : hi_i;
            it.score = SCORE_W'($urandom_range(0, 1) ? -mag : mag);
        end else if (r < 93) begin
            it.kind = KIND_DRAIN;
        end else if (r < 96) begin
            it.kind = KIND_CLEAR;
        end else begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (sel_queue.size() == 0) begin
                report_mismatch("result with none pending, sel_index", out_data.sel_index, 0);
            end else begin
                want = sel_queue.pop_front();
                if (out_data.sel_index !== want.sel_index)
                    report_mismatch("sel_index", out_data.sel_index, want.sel_index);
                if (out_data.sel_label !== want.sel_label)
                    report_mismatch("sel_label", out_data.sel_label, want.sel_label);
                if (out_data.sel_valid !== want.sel_valid)
                    report_mismatch("sel_valid", out_data.sel_valid, want.sel_valid);
                if (out_data.last !== want.last)
                    report_mismatch("last", out_data.last, want.last);
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("** band_topk_balanced_selector: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, none in the last phase
    initial begin : receiver
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 9) - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [BAND_W-1:0] lo;
        logic [BAND_W-1:0] hi;
        int                lo_i;
        t_out              empty_drain;
        heap_clear();
        band_lo     = BAND_LOW_RST;
        band_hi     = BAND_HIGH_RST;
        empty_drain = mk_sel('0, 1'b0, 1'b0, 1'b1);

        // Directed table; typed rows are empty drains
        add_row(mk_in(KIND_DRAIN, 0, 0), 1'b1, empty_drain);
        add_row(mk_in(KIND_OFFER, 8192, 16'h0010), 1'b0, '0);   // on lower bound
        add_row(mk_in(KIND_OFFER, -16384, 16'h0011), 1'b0, '0); // on upper bound
        add_row(mk_in(KIND_OFFER, 0, 16'h0012), 1'b0, '0);
        add_row(mk_in(KIND_OFFER, -32768, 16'hFFFF), 1'b0, '0);
        add_row(mk_in(KIND_OFFER, 32767, 16'h0000), 1'b0, '0);
        add_row(mk_in(KIND_UNUSED, 12000, 16'h0013), 1'b0, '0);
        add_row(mk_in(KIND_DRAIN, 0, 0), 1'b1, empty_drain);
        add_row(mk_in(KIND_OFFER, 8193, 16'h0001), 1'b0, '0);
        add_row(mk_in(KIND_OFFER, -8193, 16'hFFFF), 1'b0, '0);
        add_row(mk_in(KIND_OFFER, 16383, 16'h8000), 1'b0, '0);
        add_row(mk_in(KIND_OFFER, -16383, 16'h7FFF), 1'b0, '0);
        add_row(mk_in(KIND_DRAIN, 0, 0), 1'b0, '0);
        add_row(mk_in(KIND_OFFER, 12000, 16'h1234), 1'b0, '0);
        add_row(mk_in(KIND_DRAIN, 0, 0), 1'b0, '0);             // unbalanced
        add_row(mk_in(KIND_OFFER, 9000, 16'h0002), 1'b0, '0);
        add_row(mk_in(KIND_OFFER, 9000, 16'h0003), 1'b0, '0);   // tie
        add_row(mk_in(KIND_OFFER, -9000, 16'h0004), 1'b0, '0);
        add_row(mk_in(KIND_DRAIN, 0, 0), 1'b0, '0);
        add_row(mk_in(KIND_CLEAR, 0, 0), 1'b0, '0);
        add_row(mk_in(KIND_DRAIN, 0, 0), 1'b1, empty_drain);

        // Reset, released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[k]) send_item(dir_table[k].item, dir_table[k].typed, dir_table[k].want);

        // Random phases, each under its own band setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin lo = BAND_LOW_RST; hi = BAND_HIGH_RST; end
                1: begin lo = 15'd0;     hi = 15'd32767; end
                2: begin lo = 15'd32767; hi = 15'd0;     end  // empty band
                3: begin lo = 15'd0;     hi = 15'd1;     end  // empty band
                4: begin lo = 15'd32765; hi = 15'd32767; end  // one magnitude, all ties
                5, 6: begin
                    lo_i = $urandom_range(0, 24000);
                    lo   = BAND_W'(lo_i);
                    hi   = BAND_W'(lo_i + $urandom_range(2, 32767 - lo_i));
                end
                default: begin lo = 15'd0; hi = 15'd32767; end
            endcase
            write_bands(lo, hi);
            calm = (ph == N_PHASES - 1);
            repeat (PHASE_ITEMS) send_item(rand_item(lo, hi), 1'b0, '0);
        end

        // Drain out the pending results, then a quiet tail
        in_valid <= 1'b0;
        while (sel_queue.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("** band_topk_balanced_selector: PASSED **");
        else
            $display("** band_topk_balanced_selector: FAILED **");
        $finish;
    end

endmodule

// ===== band_topk_balanced_selector.f =====
design/bts_pkg.sv
design/bts_ram.sv
design/bts_cmp.sv
design/band_topk_balanced_selector.sv
tb/testbench.sv
